// ===== rtl/idc_pkg.sv =====
// Package for the image diff cluster check: sizes, payload structs, register
// and verdict codes, and the row store write port type.
// No dependencies; the RTL files use scoped names and the testbench imports it.
package idc_pkg;

   // Frame size limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Index and dimension widths
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DIM_REG_W = 12;
   localparam int DIM_W0 = (COL_W + 1 > ROW_W + 1) ? COL_W + 1 : ROW_W + 1;
   localparam int DIM_W = (DIM_W0 > DIM_REG_W) ? DIM_W0 : DIM_REG_W;

   // Field widths
   localparam int PIX_W    = 32;
   localparam int CHAN_W   = 8;
   localparam int NCHAN    = PIX_W / CHAN_W;
   localparam int TOL_W    = 8;
   localparam int LIMIT_W  = 4;
   localparam int TOTAL_W  = 23;
   localparam int COUNT_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Reset values of the configuration registers
   localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = DIM_REG_W'(2048);
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = DIM_REG_W'(2048);
   localparam logic [TOL_W-1:0]     TOL_RESET    = TOL_W'(3);
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = LIMIT_W'(10);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH       = 2'd0,
      CSR_FRAME_HEIGHT      = 2'd1,
      CSR_CHANNEL_TOLERANCE = 2'd2,
      CSR_CLUSTER_LIMIT     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_EXACT  = 2'd0,
      VERDICT_PASSED = 2'd1,
      VERDICT_FAILED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_first;
      logic [PIX_W-1:0] pixel_second;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] differing_pixels;
      logic [COUNT_W-1:0] largest_cluster;
      logic [1:0]         verdict;
   } rsp_type;

   // Row store write port
   typedef struct packed {
      logic               en;
      logic [COL_W-1:0]   addr;
      logic [COUNT_W-1:0] data;
   } ram_wr_type;

endpackage

// ===== rtl/idc_pair_cmp.sv =====
// Pixel pair comparator: per-channel absolute differences against the
// tolerance and their sum against four times the tolerance.
// Depends on idc_pkg for field widths.
module idc_pair_cmp (
   input  logic [idc_pkg::PIX_W-1:0] pixel_first,
   input  logic [idc_pkg::PIX_W-1:0] pixel_second,
   input  logic [idc_pkg::TOL_W-1:0] tolerance,
   output logic                      differs
);

   localparam int SUM_W = idc_pkg::CHAN_W + $clog2(idc_pkg::NCHAN);

   logic [idc_pkg::CHAN_W-1:0] chan_diff [idc_pkg::NCHAN];
   logic [idc_pkg::NCHAN-1:0]  chan_over;
   logic [SUM_W-1:0]           diff_sum;
   logic [SUM_W-1:0]           sum_limit;

   // Take absolute difference of each channel
   always_comb begin
      for (int c = 0; c < idc_pkg::NCHAN; c++) begin
         logic [idc_pkg::CHAN_W-1:0] a;
         logic [idc_pkg::CHAN_W-1:0] b;
         a = pixel_first[c*idc_pkg::CHAN_W +: idc_pkg::CHAN_W];
         b = pixel_second[c*idc_pkg::CHAN_W +: idc_pkg::CHAN_W];
         chan_diff[c] = (a > b) ? a - b : b - a;
         chan_over[c] = chan_diff[c] > tolerance;
      end
   end

   // Add the differences up and compare with four times the tolerance
   always_comb begin
      diff_sum = '0;
      for (int c = 0; c < idc_pkg::NCHAN; c++) begin
         diff_sum = diff_sum + SUM_W'(chan_diff[c]);
      end
      sum_limit = SUM_W'(tolerance) << 2;
   end

   assign differs = (|chan_over) || (diff_sum >= sum_limit);

endmodule

// ===== rtl/idc_row_ram.sv =====
// Row store: one entry per column holding the pending cluster count of the
// row above. One write and one registered read port. Depends on idc_pkg.
module idc_row_ram (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [idc_pkg::COL_W-1:0]    rd_addr,
   output logic [idc_pkg::COUNT_W-1:0]  rd_data_ff,
   input  idc_pkg::ram_wr_type          wr
);

   logic [idc_pkg::COUNT_W-1:0] mem [idc_pkg::MAX_WIDTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/image_diff_cluster_check.sv =====
// Top level of the image diff cluster check: configuration registers, raster
// counters, cluster update stage, row store forwarding and result register.
// Depends on idc_pkg, idc_pair_cmp and idc_row_ram.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | idc_pkg::req_type (pixel pair)
//   rsp_    | out       | rsp_valid/rsp_stall | idc_pkg::rsp_type (frame result)
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_data (12 bits)
//
// One pixel pair per cycle unless stalled; each pair does one read-modify-write
// of the row store, split over the accept cycle (read) and the update cycle.
// The frame result is registered as the last pair leaves the update stage.
// req_stall rises only while a finished frame result waits behind an untaken
// earlier result. Reset is synchronous; the row store needs no clearing pass.
module image_diff_cluster_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  idc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output idc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [idc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [idc_pkg::DIM_REG_W-1:0]       csr_data
);

   typedef struct packed {
      logic                      differs;
      logic [idc_pkg::COL_W-1:0] col;
      logic                      col_nz;
      logic                      row_nz;
      logic                      last_col;
      logic                      last_row;
   } stage_type;

   // Configuration registers
   logic [idc_pkg::DIM_REG_W-1:0] width_ff;
   logic [idc_pkg::DIM_REG_W-1:0] height_ff;
   logic [idc_pkg::TOL_W-1:0]     tol_ff;
   logic [idc_pkg::LIMIT_W-1:0]   limit_ff;

   // Raster counters
   logic [idc_pkg::COL_W-1:0] col_ff, col_in;
   logic [idc_pkg::ROW_W-1:0] row_ff, row_in;

   // Update stage
   stage_type                     s1_ff, s1_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          fwd_hit_ff, fwd_hit_in;
   logic [idc_pkg::COUNT_W-1:0]   fwd_data_ff, fwd_data_in;

   // Cluster state
   logic [idc_pkg::COUNT_W-1:0]   west_ff, west_in;
   logic [idc_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [idc_pkg::COUNT_W-1:0]   max_ff, max_in;

   // Deferred write of the last column
   logic                          pend_valid_ff, pend_valid_in;
   logic [idc_pkg::COL_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [idc_pkg::COUNT_W-1:0]   pend_data_ff, pend_data_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   idc_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // Combinational signals
   logic                          accept;
   logic                          s1_final;
   logic                          s1_fire;
   logic                          pair_differs;
   logic [idc_pkg::DIM_W-1:0]     width_eff, height_eff;
   logic [idc_pkg::DIM_W-1:0]     col_next_ext, row_next_ext;
   logic                          acc_last_col, acc_last_row;
   logic [idc_pkg::COUNT_W-1:0]   ram_rd_data;
   idc_pkg::ram_wr_type           ram_wr;
   logic                          dir_we;
   logic                          flush;
   logic [idc_pkg::COUNT_W-1:0]   north_raw, north, cur, west_upd, max_new;
   logic                          north_nz, west_nz;
   logic [idc_pkg::TOTAL_W-1:0]   total_next;
   idc_pkg::verdict_type          verdict;

   // ---------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= idc_pkg::WIDTH_RESET;
         height_ff <= idc_pkg::HEIGHT_RESET;
         tol_ff    <= idc_pkg::TOL_RESET;
         limit_ff  <= idc_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (idc_pkg::csr_index_type'(csr_index))
            idc_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= csr_data;
            end
            idc_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= csr_data;
            end
            idc_pkg::CSR_CHANNEL_TOLERANCE: begin
               tol_ff <= csr_data[idc_pkg::TOL_W-1:0];
            end
            idc_pkg::CSR_CLUSTER_LIMIT: begin
               limit_ff <= csr_data[idc_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the geometry to the supported range
   always_comb begin
      if (width_ff == '0) begin
         width_eff = idc_pkg::DIM_W'(1);
      end else if (idc_pkg::DIM_W'(width_ff) > idc_pkg::DIM_W'(idc_pkg::MAX_WIDTH)) begin
         width_eff = idc_pkg::DIM_W'(idc_pkg::MAX_WIDTH);
      end else begin
         width_eff = idc_pkg::DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = idc_pkg::DIM_W'(1);
      end else if (idc_pkg::DIM_W'(height_ff) > idc_pkg::DIM_W'(idc_pkg::MAX_HEIGHT)) begin
         height_eff = idc_pkg::DIM_W'(idc_pkg::MAX_HEIGHT);
      end else begin
         height_eff = idc_pkg::DIM_W'(height_ff);
      end
   end

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   assign s1_final  = s1_ff.last_col && s1_ff.last_row;
   assign s1_fire   = s1_valid_ff && !(s1_final && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Accept stage: compare, position, row store read
   // ---------------------------------------------------------------
   idc_pair_cmp u_cmp (
      .pixel_first  (req_data.pixel_first),
      .pixel_second (req_data.pixel_second),
      .tolerance    (tol_ff),
      .differs      (pair_differs)
   );

   assign col_next_ext = idc_pkg::DIM_W'(col_ff) + idc_pkg::DIM_W'(1);
   assign row_next_ext = idc_pkg::DIM_W'(row_ff) + idc_pkg::DIM_W'(1);
   assign acc_last_col = col_next_ext >= width_eff;
   assign acc_last_row = row_next_ext >= height_eff;

   // Advance the raster position on each transfer
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!acc_last_col) begin
            col_in = col_next_ext[idc_pkg::COL_W-1:0];
         end else begin
            col_in = '0;
            row_in = acc_last_row ? '0 : row_next_ext[idc_pkg::ROW_W-1:0];
         end
      end
   end

   always_comb begin
      s1_in.differs  = pair_differs;
      s1_in.col      = col_ff;
      s1_in.col_nz   = col_ff != '0;
      s1_in.row_nz   = row_ff != '0;
      s1_in.last_col = acc_last_col;
      s1_in.last_row = acc_last_row;
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Forward data written in the read cycle; the deferred entry is the newest
   always_comb begin
      fwd_hit_in  = 1'b0;
      fwd_data_in = ram_wr.data;
      if (pend_valid_in && pend_addr_in == col_ff) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = pend_data_in;
      end else if (ram_wr.en && ram_wr.addr == col_ff) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = ram_wr.data;
      end
   end

   idc_row_ram u_ram (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (col_ff),
      .rd_data_ff (ram_rd_data),
      .wr         (ram_wr)
   );

   // ---------------------------------------------------------------
   // Update stage: cluster counts and row store write back
   // ---------------------------------------------------------------
   always_comb begin
      north_raw = s1_ff.row_nz ? (fwd_hit_ff ? fwd_data_ff : ram_rd_data) : '0;
      north_nz  = north_raw != '0;
      north     = north_raw + idc_pkg::COUNT_W'(north_nz && s1_ff.differs);
      west_nz   = west_ff != '0;
      cur       = s1_ff.differs
                  ? idc_pkg::COUNT_W'(1) + idc_pkg::COUNT_W'(north_nz)
                    + idc_pkg::COUNT_W'(s1_ff.col_nz && west_nz)
                  : '0;
      west_upd  = west_ff + idc_pkg::COUNT_W'(west_nz && s1_ff.differs);
   end

   // Track the largest closed cluster
   always_comb begin
      max_new = max_ff;
      if (north_nz && north > max_new) begin
         max_new = north;
      end
      if (s1_ff.col_nz && s1_ff.last_row && west_upd > max_new) begin
         max_new = west_upd;
      end
      if (s1_final && cur > max_new) begin
         max_new = cur;
      end
   end

   assign total_next = (s1_ff.differs && total_ff != idc_pkg::TOTAL_MAX)
                       ? total_ff + idc_pkg::TOTAL_W'(1) : total_ff;

   always_comb begin
      if (total_next == '0) begin
         verdict = idc_pkg::VERDICT_EXACT;
      end else if (idc_pkg::LIMIT_W'(max_new) >= limit_ff) begin
         verdict = idc_pkg::VERDICT_FAILED;
      end else begin
         verdict = idc_pkg::VERDICT_PASSED;
      end
   end

   // Write the west pixel back directly, drain the deferred entry otherwise
   assign dir_we = s1_fire && s1_ff.col_nz && !s1_ff.last_row;
   assign flush  = pend_valid_ff && !dir_we;

   always_comb begin
      ram_wr.en   = dir_we || flush;
      ram_wr.addr = dir_we ? s1_ff.col - idc_pkg::COL_W'(1) : pend_addr_ff;
      ram_wr.data = dir_we ? west_upd : pend_data_ff;
   end

   // Defer the last column entry to the next free write slot
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (s1_fire && s1_ff.last_col && !s1_ff.last_row) begin
         pend_valid_in = 1'b1;
         pend_addr_in  = s1_ff.col;
         pend_data_in  = cur;
      end else if (flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // Advance cluster state and load the frame result
   always_comb begin
      west_in      = west_ff;
      total_in     = total_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         if (s1_final) begin
            west_in      = '0;
            total_in     = '0;
            max_in       = idc_pkg::COUNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_data_in.differing_pixels = total_next;
            rsp_data_in.largest_cluster  = max_new;
            rsp_data_in.verdict          = verdict;
         end else begin
            west_in  = s1_ff.last_col ? '0 : cur;
            total_in = total_next;
            max_in   = max_new;
         end
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         west_ff       <= '0;
         total_ff      <= '0;
         max_ff        <= idc_pkg::COUNT_W'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         west_ff       <= west_in;
         total_ff      <= total_in;
         max_ff        <= max_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold payload registers without reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= fwd_data_in;
      end
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // A new deferred entry never meets a direct write with one still queued
   a_no_lost_write: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_ff.last_col && !s1_ff.last_row) |-> !(pend_valid_ff && dir_we))
      else $error("deferred row store write dropped");

   // A result appears only after the last pair of a frame is processed
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s1_fire && s1_final))
      else $error("result without frame end");

   // The running cluster maximum stays within one to five
   a_max_range: assert property (@(posedge clock) disable iff (reset)
      (max_ff >= idc_pkg::COUNT_W'(1)) && (max_ff <= idc_pkg::COUNT_W'(5)))
      else $error("cluster maximum out of range");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for image_diff_cluster_check: streams pixel-pair frames under random
// idling and back-pressure and checks every frame result against a cycle-free
// model of the diff count, cluster peak and verdict. Depends on idc_pkg.
module tb_top;
   import idc_pkg::*;

   // Frame model: mirrors the raster walk, the row store and the west count
   class cluster_frame_model;
      bit [DIM_REG_W-1:0] width_reg;
      bit [DIM_REG_W-1:0] height_reg;
      bit [TOL_W-1:0]     tolerance;
      bit [LIMIT_W-1:0]   limit_reg;
      bit [COUNT_W-1:0]   row_store [MAX_WIDTH];
      int unsigned        west_count;
      int unsigned        column;
      int unsigned        row_pos;
      int unsigned        diff_total;
      int unsigned        peak;
      rsp_type            expected_frames [$];
      int unsigned        mismatches;
      int unsigned        frames_checked;
      int unsigned        pairs_seen;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         tolerance  = TOL_RESET;
         limit_reg  = LIMIT_RESET;
         foreach (row_store[i]) row_store[i] = '0;
         mismatches     = 0;
         frames_checked = 0;
         pairs_seen     = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         west_count = 0;
         column     = 0;
         row_pos    = 0;
         diff_total = 0;
         peak       = 1;
      endfunction

      // Zero acts as one, anything past the maximum as the maximum
      function int unsigned eff_dim(bit [DIM_REG_W-1:0] v, int unsigned maxv);
         if (v == 0) return 1;
         return (32'(v) > maxv) ? maxv : 32'(v);
      endfunction

      function int unsigned frame_pixels();
         return eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
      endfunction

      function void write_reg(csr_index_type idx, bit [DIM_REG_W-1:0] v);
         case (idx)
            CSR_FRAME_WIDTH:       width_reg  = v;
            CSR_FRAME_HEIGHT:      height_reg = v;
            CSR_CHANNEL_TOLERANCE: tolerance  = v[TOL_W-1:0];
            CSR_CLUSTER_LIMIT:     limit_reg  = v[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function bit pair_differs(bit [PIX_W-1:0] a, bit [PIX_W-1:0] b);
         int unsigned sum;
         int unsigned ca;
         int unsigned cb;
         int unsigned dd;
         sum = 0;
         for (int ch = 0; ch < NCHAN; ch++) begin
            ca = 32'(a[CHAN_W*ch +: CHAN_W]);
            cb = 32'(b[CHAN_W*ch +: CHAN_W]);
            dd = (ca > cb) ? ca - cb : cb - ca;
            if (dd > 32'(tolerance)) return 1'b1;
            sum += dd;
         end
         return sum >= 4 * 32'(tolerance);
      endfunction

      function void raise_peak(int unsigned count);
         if (count > peak) peak = count;
      endfunction

      // Advance the raster walk by one accepted pair; queue a result at frame end
      function void note_pair(req_type p);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         int unsigned y;
         int unsigned north;
         int unsigned cur;
         int unsigned wc;
         bit          last_col;
         bit          last_row;
         bit          d;
         rsp_type     r;
         verdict_type v;
         pairs_seen++;
         w = eff_dim(width_reg, MAX_WIDTH);
         h = eff_dim(height_reg, MAX_HEIGHT);
         x = column % MAX_WIDTH;
         y = row_pos;
         last_col = (x + 1 >= w);
         last_row = (y + 1 >= h);
         d = pair_differs(p.pixel_first, p.pixel_second);
         north = 0;
         cur = 0;

         // close out the pixel above: it now knows its south neighbour
         if (y > 0) begin
            north = 32'(row_store[x[COL_W-1:0]]);
            if (north != 0 && d) north++;
            if (north != 0) raise_peak(north);
         end

         if (d) cur = 1 + ((north != 0) ? 1 : 0) + ((x > 0 && west_count != 0) ? 1 : 0);

         // west pixel now knows its east neighbour
         if (x > 0) begin
            wc = west_count;
            if (wc != 0 && d) wc++;
            if (last_row) raise_peak(wc);
            else row_store[COL_W'(x - 1)] = COUNT_W'(wc);
         end
         west_count = cur;

         if (d && diff_total < 32'(TOTAL_MAX)) diff_total++;

         if (!last_col) begin
            column = x + 1;
            return;
         end

         if (last_row) raise_peak(cur);
         else row_store[x[COL_W-1:0]] = COUNT_W'(cur);
         west_count = 0;
         column = 0;

         if (!last_row) begin
            row_pos = y + 1;
            return;
         end

         if (diff_total == 0) v = VERDICT_EXACT;
         else if (peak >= 32'(limit_reg)) v = VERDICT_FAILED;
         else v = VERDICT_PASSED;
         r.differing_pixels = TOTAL_W'(diff_total);
         r.largest_cluster  = COUNT_W'(peak);
         r.verdict          = v;
         expected_frames.push_back(r);
         restart_frame();
      endfunction

      // Compare one result transfer with the oldest expected frame
      function void check_result(rsp_type got);
         rsp_type exp_r;
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d", $time,
                     got.differing_pixels, got.largest_cluster, got.verdict);
            mismatches++;
            return;
         end
         exp_r = expected_frames.pop_front();
         frames_checked++;
         if (got.differing_pixels !== exp_r.differing_pixels) begin
            $display("%0t: differing_pixels expected %0d actual %0d", $time,
                     exp_r.differing_pixels, got.differing_pixels);
            mismatches++;
         end
         if (got.largest_cluster !== exp_r.largest_cluster) begin
            $display("%0t: largest_cluster expected %0d actual %0d", $time,
                     exp_r.largest_cluster, got.largest_cluster);
            mismatches++;
         end
         if (got.verdict !== exp_r.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time,
                     exp_r.verdict, got.verdict);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [DIM_REG_W-1:0]  csr_data;

   cluster_frame_model frame_model;
   bit                 sender_gaps;
   bit                 receiver_gaps;
   bit                 hold_armed;
   int unsigned        pairs_sent;
   int unsigned        settings_count;

   image_diff_cluster_check u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Known values on every input from time zero
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      sender_gaps    = 1'b1;
      receiver_gaps  = 1'b1;
      hold_armed     = 1'b0;
      pairs_sent     = 0;
      settings_count = 0;
      frame_model    = new();
   end

   // Observe every transfer on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) frame_model.write_reg(csr_index_type'(csr_index), csr_data);
         if (req_valid && !req_stall) frame_model.note_pair(req_data);
         if (rsp_valid && !rsp_stall) frame_model.check_result(rsp_data);
      end
   end

   // Result side: stall a drawn number of cycles before each transfer
   initial begin : result_taker
      int unsigned hold;
      @(negedge reset);
      forever begin
         if (hold_armed) begin
            hold = 150;
            hold_armed = 1'b0;
         end else begin
            hold = receiver_gaps ? $urandom_range(0, 4) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Drop a generous bound on the whole run
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_pair(input req_type p);
      int unsigned gap;
      gap = sender_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pairs_sent++;
   endtask

   task automatic send_raw(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
      req_type p;
      p.pixel_first  = a;
      p.pixel_second = b;
      send_pair(p);
   endtask

   // Hold the sender until every expected frame result has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_model.expected_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DIM_REG_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h,
                            input logic [DIM_REG_W-1:0] tol, input logic [DIM_REG_W-1:0] lim);
      wait_drained();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_CHANNEL_TOLERANCE, tol);
      write_csr(CSR_CLUSTER_LIMIT, lim);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Random pair: mostly near matches, some large or all-channel differences
   function automatic req_type make_pair(int unsigned diff_pct);
      req_type     p;
      int unsigned ch;
      int unsigned tol;
      tol = 32'(frame_model.tolerance);
      p.pixel_first  = $urandom;
      p.pixel_second = p.pixel_first;
      if ($urandom_range(0, 99) < diff_pct) begin
         case ($urandom_range(0, 3))
            0: p.pixel_second = $urandom;
            1: begin
               ch = $urandom_range(0, NCHAN - 1);
               p.pixel_second[CHAN_W*ch +: CHAN_W] =
                  p.pixel_first[CHAN_W*ch +: CHAN_W] + CHAN_W'($urandom_range(1, 255));
            end
            2: begin
               for (ch = 0; ch < NCHAN; ch++)
                  p.pixel_second[CHAN_W*ch +: CHAN_W] =
                     p.pixel_first[CHAN_W*ch +: CHAN_W] - CHAN_W'($urandom_range(0, tol + 1));
            end
            default: begin
               for (ch = 0; ch < NCHAN; ch++)
                  p.pixel_first[CHAN_W*ch +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               p.pixel_second = ~p.pixel_first;
            end
         endcase
      end else if ($urandom_range(0, 1)) begin
         for (ch = 0; ch < NCHAN; ch++)
            p.pixel_second[CHAN_W*ch +: CHAN_W] =
               p.pixel_first[CHAN_W*ch +: CHAN_W] + CHAN_W'($urandom_range(0, tol / 2));
      end
      return p;
   endfunction

   task automatic send_frame(input int unsigned diff_pct);
      int unsigned n;
      n = frame_model.frame_pixels();
      repeat (n) send_pair(make_pair(diff_pct));
   endtask

   initial begin : stimulus
      int unsigned random_start;
      int unsigned frames;
      int unsigned pct;
      logic [DIM_REG_W-1:0] w;
      logic [DIM_REG_W-1:0] h;
      logic [DIM_REG_W-1:0] tol;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // plus-shaped cluster of five in a 3x3 frame, one test per pixel
      configure(3, 3, 3, 5);
      send_raw(32'h0000_0000, 32'h0000_0000);
      send_raw(32'h0000_0000, 32'hFFFF_FFFF);
      send_raw(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_raw(32'h0400_0000, 32'h0000_0000);   // alpha one past tolerance
      send_raw(32'h0303_0303, 32'h0000_0000);   // sum reaches four times tolerance
      send_raw(32'h0000_0080, 32'h0000_0084);   // blue one past tolerance
      send_raw(32'h0202_0202, 32'h0000_0000);   // sum just short
      send_raw(32'h0000_0000, 32'h00FF_0000);   // red at full swing
      send_raw(32'h0000_0300, 32'h0000_0000);   // green at tolerance

      // zero geometry acts as 1x1; zero tolerance makes equal pairs differ
      configure(0, 0, 0, 0);
      send_raw(32'h0000_0000, 32'h0000_0000);
      send_raw(32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // full tolerance: only a full swing on all channels differs
      configure(2, 1, 255, 15);
      send_raw(32'h0000_0000, 32'hFFFF_FFFF);
      send_raw(32'h00FF_00FF, 32'hFF00_FF00);
      send_raw(32'h1234_5678, 32'h1234_5678);
      send_raw(32'hFEFE_FEFE, 32'h0000_0000);

      // vertical pair against the smallest limit
      configure(1, 2, 3, 1);
      send_raw(32'h0000_0000, 32'hFFFF_FFFF);
      send_raw(32'hFFFF_FFFF, 32'h0000_0000);

      // long result hold with one-pixel frames so the block backs up
      configure(1, 1, 3, 15);
      sender_gaps = 1'b0;
      hold_armed  = 1'b1;
      repeat (40) send_pair(make_pair(50));
      sender_gaps = 1'b1;

      // random settings, mostly small frames
      random_start = pairs_sent;
      while (pairs_sent - random_start < 690) begin
         w = ($urandom_range(0, 9) < 8) ? DIM_REG_W'($urandom_range(0, 6))
                                        : DIM_REG_W'($urandom_range(7, 40));
         h = DIM_REG_W'($urandom_range(0, 5));
         case ($urandom_range(0, 5))
            0: tol = '0;
            1: tol = DIM_REG_W'(1);
            2: tol = DIM_REG_W'(3);
            3: tol = DIM_REG_W'(255);
            default: tol = DIM_REG_W'($urandom_range(0, 20));
         endcase
         configure(w, h, tol, DIM_REG_W'($urandom_range(0, 15)));
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         frames = $urandom_range(1, 4);
         repeat (frames) begin
            pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 60);
            send_frame(pct);
         end
      end

      wait_drained();
      $display("Checked %0d frame results from %0d pixel pairs over %0d register settings.",
               frame_model.frames_checked, frame_model.pairs_seen, settings_count);
      $display("Geometry ran from 1x1 to 40 columns by 5 rows, tolerance 0 to 255, long hold.");
      if (frame_model.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/idc_pkg.sv
rtl/idc_pair_cmp.sv
rtl/idc_row_ram.sv
rtl/image_diff_cluster_check.sv
verif/tb_top.sv
